/* hdl/fvnh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fvnh_pkg: shared types and constants
// Transaction structs and constants for the fractal value-noise height block.
// ----------------------------------------------------------------------------
package fvnh_pkg;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic [14:0] height_fine;
        logic [6:0]  height_level;
    } out_item_t;

    localparam logic [0:0] REG_FLOOR   = 1'b0;
    localparam logic [0:0] REG_CEILING = 1'b1;

    localparam logic [31:0] SCALE0 = 32'd21474836;
    localparam logic [31:0] SCALE1 = 32'd85899346;
    localparam logic [31:0] SCALE2 = 32'd429496730;
    localparam logic [31:0] MIX_X  = 32'd374761393;
    localparam logic [31:0] MIX_Z  = 32'd668265263;
    localparam logic [31:0] MIX_K  = 32'h9e3779b1;
    localparam logic [31:0] FIN_M1 = 32'h7feb352d;
    localparam logic [31:0] FIN_M2 = 32'h846ca68b;
    localparam int unsigned HASH_MOD = 10000;

endpackage : fvnh_pkg
`default_nettype wire

/* hdl/fvnh_octave.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fvnh_octave: one octave of 2D value noise
// Pipelined lattice split, corner hashing, modulo, smoothstep and bilinear
// blend. Fixed latency; advances when en is high.
// ----------------------------------------------------------------------------
module fvnh_octave #(
    parameter int FRAC_BITS = 16,
    parameter logic [31:0] SCALE = 32'd21474836
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic signed [23:0]    pos_x,
    input  wire logic signed [23:0]    pos_z,
    output logic [FRAC_BITS:0]         noise
);
    import fvnh_pkg::*;

    localparam int F = FRAC_BITS;
    localparam int PW = 57;
    localparam logic [F:0] ONE = (F+1)'(1) << F;
    // reciprocal for exact floor(v/10000), v < 2^32
    localparam logic [63:0] RECIP = 64'd3518437209;  // ceil(2^45/10000)
    localparam int RSH = 45;
    // reciprocal for exact floor((r << F) / 10000), r < 10000
    localparam logic [63:0] FRAC_RECIP = ((64'd1 << (32 + F)) + 64'd9999) / 64'd10000;

    // S1: scale products
    logic signed [PW-1:0] px_reg, pz_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= PW'(pos_x) * $signed({1'b0, SCALE});
            pz_reg <= PW'(pos_z) * $signed({1'b0, SCALE});
        end
    end

    // split into cell (floor of Q40 value, sign-extended) and fraction
    logic [31:0] cx, cz;
    logic [F-1:0] tx, tz;
    assign cx = 32'(px_reg >>> 40);
    assign cz = 32'(pz_reg >>> 40);
    assign tx = px_reg[40-F +: F];
    assign tz = pz_reg[40-F +: F];

    // S2: coordinate mix products per corner
    logic [31:0] mxa_reg [2], mza_reg [2];
    logic [F-1:0] tx2_reg, tz2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mxa_reg[0] <= 32'(cx * MIX_X);
            mxa_reg[1] <= 32'((cx + 32'd1) * MIX_X);
            mza_reg[0] <= 32'(cz * MIX_Z);
            mza_reg[1] <= 32'((cz + 32'd1) * MIX_Z);
            tx2_reg <= tx;
            tz2_reg <= tz;
        end
    end

    // S3: xor and first finalizer multiply; smoothstep square
    logic [31:0] h3_reg [4];
    logic [F-1:0] tx3_reg, tz3_reg;
    logic [F:0] sqx3_reg, sqz3_reg;
    always_ff @(posedge clk)
    begin
        logic [31:0] v;
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                v = mxa_reg[i%2] ^ mza_reg[i/2] ^ MIX_K;
                v = v ^ (v >> 16);
                h3_reg[i] <= 32'(v * FIN_M1);
            end
            sqx3_reg <= (F+1)'(({{F{1'b0}}, tx2_reg} * {{F{1'b0}}, tx2_reg}) >> F);
            sqz3_reg <= (F+1)'(({{F{1'b0}}, tz2_reg} * {{F{1'b0}}, tz2_reg}) >> F);
            tx3_reg <= tx2_reg;
            tz3_reg <= tz2_reg;
        end
    end

    // S4: second finalizer multiply; smoothstep cubic
    logic [31:0] h4_reg [4];
    logic [F:0] sx4_reg, sz4_reg;
    always_ff @(posedge clk)
    begin
        logic [31:0] v;
        logic [F+2:0] kx, kz;
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                v = h3_reg[i] ^ (h3_reg[i] >> 15);
                h4_reg[i] <= 32'(v * FIN_M2);
            end
            kx = (F+3)'(3) * (F+3)'(ONE) - ((F+3)'(tx3_reg) << 1);
            kz = (F+3)'(3) * (F+3)'(ONE) - ((F+3)'(tz3_reg) << 1);
            sx4_reg <= (F+1)'(({{(F+2){1'b0}}, sqx3_reg} * {{F{1'b0}}, kx}) >> F);
            sz4_reg <= (F+1)'(({{(F+2){1'b0}}, sqz3_reg} * {{F{1'b0}}, kz}) >> F);
        end
    end

    // S5: quotient estimate for mod 10000
    logic [31:0] h5_reg [4];
    logic [18:0] q5_reg [4];
    logic [F:0] sx5_reg, sz5_reg;
    always_ff @(posedge clk)
    begin
        logic [31:0] v;
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                v = h4_reg[i] ^ (h4_reg[i] >> 16);
                h5_reg[i] <= v;
                q5_reg[i] <= 19'(({32'd0, v} * RECIP) >> RSH);
            end
            sx5_reg <= sx4_reg;
            sz5_reg <= sz4_reg;
        end
    end

    // S6: remainder
    logic [13:0] r6_reg [4];
    logic [F:0] sx6_reg, sz6_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                r6_reg[i] <= 14'(h5_reg[i] - 32'(q5_reg[i] * 32'(HASH_MOD)));
            sx6_reg <= sx5_reg;
            sz6_reg <= sz5_reg;
        end
    end

    // S7: corner fraction floor((r << F) / 10000) by reciprocal multiply
    logic [F-1:0] f7_reg [4];
    logic [F:0] sx7_reg, sz7_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                f7_reg[i] <= F'(({50'd0, r6_reg[i]} * FRAC_RECIP) >> 32);
            sx7_reg <= sx6_reg;
            sz7_reg <= sz6_reg;
        end
    end

    // S8: balance stage, corner fractions and weights held
    logic [F-1:0] f8_reg [4];
    logic [F:0] sx8_reg, sz8_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                f8_reg[i] <= f7_reg[i];
            sx8_reg <= sx7_reg;
            sz8_reg <= sz7_reg;
        end
    end

    // S9: blend along x
    logic [F-1:0] row9_reg [2];
    logic [F:0] sz9_reg;
    always_ff @(posedge clk)
    begin
        logic [2*F+1:0] acc;
        if (en)
        begin
            for (int r = 0; r < 2; r++)
            begin
                acc = (2*F+2)'(f8_reg[2*r]) * (2*F+2)'(ONE - sx8_reg)
                    + (2*F+2)'(f8_reg[2*r+1]) * (2*F+2)'(sx8_reg);
                row9_reg[r] <= F'(acc >> F);
            end
            sz9_reg <= sz8_reg;
        end
    end

    // S10: blend along z
    always_ff @(posedge clk)
    begin
        logic [2*F+1:0] acc;
        if (en)
        begin
            acc = (2*F+2)'(row9_reg[0]) * (2*F+2)'(ONE - sz9_reg)
                + (2*F+2)'(row9_reg[1]) * (2*F+2)'(sz9_reg);
            noise <= (F+1)'(acc >> F);
        end
    end
endmodule : fvnh_octave
`default_nettype wire

/* hdl/fractal_value_noise_height.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fractal_value_noise_height: terrain height from three value-noise octaves
// Usage:
//   in_valid/in_stall/in_data carry one (pos_x, pos_z) transaction per cycle while in_stall is low;
//   out_valid/out_stall/out_data return one height transaction per input.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write height_floor (0) and
//   height_ceiling (1); cfg_ready is always high.
// Pipeline: the fully pipelined octave units (ten stages each), then a gain
//   sum register and an output register after the combinational clamp.
// Throughput: one transaction per cycle while the output is not stalled.
// Stall: the whole pipeline holds while out_valid is high and out_stall is high;
//   in_stall follows that condition, so nothing is lost or repeated.
// Reset: clears all valid bits and loads floor 1, ceiling 80.
// ----------------------------------------------------------------------------
module fractal_value_noise_height #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire fvnh_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output fvnh_pkg::out_item_t    out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [6:0]        cfg_data
);
    import fvnh_pkg::*;

    localparam int F = FRAC_BITS;
    localparam int DEPTH = 12;

    logic en;
    logic [DEPTH-1:0] vld_reg;
    logic [6:0] floor_reg, ceil_reg;
    logic [F:0] n0, n1, n2;

    assign en = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !en;
    assign cfg_ready = 1'b1;
    assign out_valid = vld_reg[DEPTH-1];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= 7'd1;
            ceil_reg  <= 7'd80;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FLOOR:   floor_reg <= cfg_data;
                REG_CEILING: ceil_reg  <= cfg_data;
                default:     floor_reg <= floor_reg;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    fvnh_octave #(.FRAC_BITS(F), .SCALE(SCALE0)) u_oct0 (
        .clk(clk), .en(en), .pos_x(in_data.pos_x), .pos_z(in_data.pos_z), .noise(n0));
    fvnh_octave #(.FRAC_BITS(F), .SCALE(SCALE1)) u_oct1 (
        .clk(clk), .en(en), .pos_x(in_data.pos_x), .pos_z(in_data.pos_z), .noise(n1));
    fvnh_octave #(.FRAC_BITS(F), .SCALE(SCALE2)) u_oct2 (
        .clk(clk), .en(en), .pos_x(in_data.pos_x), .pos_z(in_data.pos_z), .noise(n2));

    // gain sum at full fraction width; floored to 8 fraction bits in the clamp below
    logic [F+7:0] sum_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            sum_reg <= (F+8)'(n0) * (F+8)'(30) + (F+8)'(n1) * (F+8)'(10)
                     + (F+8)'(n2) * (F+8)'(3);
    end

    // clamp, floor limit first then ceiling (sum < 43 blocks, fits 15 bits)
    logic [14:0] h;
    logic [14:0] lo, hi, hc;
    always_comb
    begin
        h  = 15'(sum_reg >> (F - 8));
        lo = {floor_reg, 8'd0};
        hi = {ceil_reg, 8'd0};
        hc = h;
        if (lo > h)
            hc = lo;
        if (hc > hi)
            hc = hi;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data.height_fine  <= hc;
            out_data.height_level <= hc[14:8];
        end
    end
endmodule : fractal_value_noise_height
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for fractal_value_noise_height
// Drives positions, predicts each height with a local fixed-point model of the
// three noise octaves and the clamp, and checks results in order. Both sides
// idle in random bursts, except in the final calm phase; limits are changed between phases while idle.
// ----------------------------------------------------------------------------
module tb;
    import fvnh_pkg::*;

    localparam int FB = 16;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [0:0] cfg_index;
    logic [6:0] cfg_data;

    logic [6:0] floor_lim;
    logic [6:0] ceil_lim;
    out_item_t  heights_due[$];
    int         err_count;
    bit         calm;

    fractal_value_noise_height dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // hash finalizer
    function automatic logic [31:0] finish_hash(input logic [31:0] v);
        v = v ^ (v >> 16);
        v = v * FIN_M1;
        v = v ^ (v >> 15);
        v = v * FIN_M2;
        v = v ^ (v >> 16);
        return v;
    endfunction

    function automatic longint unsigned lattice_value(input logic [31:0] cx,
                                                      input logic [31:0] cz);
        logic [31:0] h;
        h = finish_hash((cx * MIX_X) ^ (cz * MIX_Z) ^ MIX_K);
        return (longint'(h % HASH_MOD) << FB) / HASH_MOD;
    endfunction

    function automatic longint unsigned ease(input longint unsigned t);
        longint unsigned t2;
        t2 = (t * t) >> FB;
        return (t2 * (3 * (64'd1 << FB) - 2 * t)) >> FB;
    endfunction

    function automatic longint unsigned mix(input longint unsigned a,
                                            input longint unsigned b,
                                            input longint unsigned w);
        return (a * ((64'd1 << FB) - w) + b * w) >> FB;
    endfunction

    // one octave: cell split, four corner hashes, smooth bilinear blend
    function automatic longint unsigned octave_noise(input logic signed [23:0] x,
                                                     input logic signed [23:0] z,
                                                     input logic [31:0] scale);
        logic [63:0] px, pz;
        logic [31:0] cx, cz;
        longint unsigned tx, tz, sx, sz;
        px = 64'(longint'(x) * longint'({1'b0, scale})) + (64'd1 << 55);
        pz = 64'(longint'(z) * longint'({1'b0, scale})) + (64'd1 << 55);
        cx = px[63:40] - 32'd32768;
        cz = pz[63:40] - 32'd32768;
        tx = (px >> (40 - FB)) & ((64'd1 << FB) - 1);
        tz = (pz >> (40 - FB)) & ((64'd1 << FB) - 1);
        sx = ease(tx);
        sz = ease(tz);
        return mix(mix(lattice_value(cx, cz), lattice_value(cx + 1, cz), sx),
                   mix(lattice_value(cx, cz + 1), lattice_value(cx + 1, cz + 1), sx),
                   sz);
    endfunction

    function automatic out_item_t terrain_height(input in_item_t p);
        longint unsigned h, lo, hi;
        out_item_t r;
        h = 30 * octave_noise(p.pos_x, p.pos_z, SCALE0)
          + 10 * octave_noise(p.pos_x, p.pos_z, SCALE1)
          + 3 * octave_noise(p.pos_x, p.pos_z, SCALE2);
        h = h >> (FB - 8);
        lo = longint'(floor_lim) << 8;
        hi = longint'(ceil_lim) << 8;
        if (h < lo) h = lo;
        if (h > hi) h = hi;
        r.height_fine = h[14:0];
        r.height_level = h[14:8];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch: %s", msg);
        err_count++;
    endtask

    // send one position, with random idle bursts before it; valid stays high
    // after acceptance so the next transaction can follow back to back
    task automatic send_position(input logic signed [23:0] x, input logic signed [23:0] z);
        in_item_t p;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        p.pos_x = x;
        p.pos_z = z;
        in_data <= p;
        in_valid <= 1'b1;
        heights_due.push_back(terrain_height(p));
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // write one limit register while idle
    task automatic write_limit(input logic [0:0] idx, input logic [6:0] val);
        in_valid <= 1'b0;
        while (heights_due.size() != 0) @(negedge clk);
        repeat (16) @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_FLOOR) floor_lim = val;
        else ceil_lim = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // output stall bursts
    always @(negedge clk)
    begin
        if (!calm && $urandom_range(0, 5) == 0)
            out_stall <= 1'b1;
        else if (calm || $urandom_range(0, 2) == 0)
            out_stall <= 1'b0;
    end

    // result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (heights_due.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = heights_due.pop_front();
                if (out_data.height_fine !== want.height_fine)
                    report_mismatch($sformatf("height_fine %0d want %0d",
                        out_data.height_fine, want.height_fine));
                if (out_data.height_level !== want.height_level)
                    report_mismatch($sformatf("height_level %0d want %0d",
                        out_data.height_level, want.height_level));
            end
        end
    end

    task automatic test_field_extremes();
        logic signed [23:0] ext[4];
        ext = '{24'sh800000, 24'sh7fffff, 24'sh0, -24'sd1};
        foreach (ext[i])
            foreach (ext[j])
                send_position(ext[i], ext[j]);
        // cell edges and lattice wrap neighbourhood
        send_position(24'sd51200, 24'sd256);
        send_position(24'sd12800, -24'sd12800);
        send_position(24'sd2560, 24'sd2559);
        send_position(24'sh555555, 24'shaaaaaa);
    endtask

    task automatic test_random_positions(input int n);
        repeat (n)
            if ($urandom_range(0, 3) == 0)
                send_position(24'($urandom_range(0, 4000)) - 24'sd2000,
                              24'($urandom_range(0, 4000)) - 24'sd2000);
            else
                send_position(24'($urandom), 24'($urandom));
    endtask

    // limit settings including extremes and floor above ceiling
    task automatic test_clamp_settings();
        write_limit(REG_FLOOR, 7'd0);
        write_limit(REG_CEILING, 7'd127);
        test_random_positions(120);
        write_limit(REG_FLOOR, 7'd127);
        write_limit(REG_CEILING, 7'd0);
        test_random_positions(40);
        write_limit(REG_FLOOR, 7'd30);
        write_limit(REG_CEILING, 7'd20);
        test_random_positions(40);
        write_limit(REG_FLOOR, 7'd20);
        write_limit(REG_CEILING, 7'd25);
        test_random_positions(100);
        write_limit(REG_FLOOR, 7'($urandom_range(0, 40)));
        write_limit(REG_CEILING, 7'($urandom_range(20, 127)));
        test_random_positions(150);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_FLOOR;
        cfg_data = '0;
        floor_lim = 7'd1;
        ceil_lim = 7'd80;
        err_count = 0;
        calm = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_field_extremes();
        test_random_positions(100);
        test_clamp_settings();
        calm = 1'b1;
        test_random_positions(150);

        in_valid <= 1'b0;
        while (heights_due.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("tb: done, errors");
        $finish;
    end
endmodule
